// ===== hw/rtl/mfhic_pkg.sv =====
// ----------------------------------------------------------------------------
// mfhic_pkg: shared types and constants for the magnetometer filter core
// Field widths, reset values, register indexes and calibration constants.
// ----------------------------------------------------------------------------
package mfhic_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ACC_W    = 32;
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 15;
  localparam int CNT_W    = 11;

  // Samples per calibration run (fits in CNT_W bits)
  localparam logic [CNT_W-1:0] CAL_SAMPLES = 11'd2000;

  // Reset values of the extremes tracker
  localparam logic signed [SAMPLE_W-1:0] EXT_MAX_INIT = -16'sd1000;
  localparam logic signed [SAMPLE_W-1:0] EXT_MIN_INIT = 16'sd1000;

  localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd3873;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 15'd400;

  typedef logic signed [SAMPLE_W-1:0] s16_t;
  typedef logic [2:0][SAMPLE_W-1:0]   vec3_t;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_FILTER_GAIN = 1'b0,
    REG_FIELD_LIMIT = 1'b1
  } reg_idx_t;

  // Calibration status handed from the tracker to the top level
  typedef struct packed {
    logic active_nxt;
    logic done_nxt;
  } cal_status_t;

endpackage

// ===== hw/rtl/mfhic_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mfhic_cfg_regs: configuration register file
// APB-style write/read of filter gain and field limit.
// ----------------------------------------------------------------------------
module mfhic_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [2:0]                     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready,
  output logic [mfhic_pkg::GAIN_W-1:0]   filter_gain,
  output logic [mfhic_pkg::LIMIT_W-1:0]  field_limit
);

  logic [mfhic_pkg::GAIN_W-1:0]  gain_r;
  logic [mfhic_pkg::LIMIT_W-1:0] limit_r;
  logic                          wr_en;
  mfhic_pkg::reg_idx_t           idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = mfhic_pkg::reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= mfhic_pkg::GAIN_RST;
      limit_r <= mfhic_pkg::LIMIT_RST;
    end else if (wr_en) begin
      unique case (idx)
        mfhic_pkg::REG_FILTER_GAIN: gain_r  <= cfg_pwdata[mfhic_pkg::GAIN_W-1:0];
        mfhic_pkg::REG_FIELD_LIMIT: limit_r <= cfg_pwdata[mfhic_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      mfhic_pkg::REG_FILTER_GAIN: cfg_prdata = {16'h0, gain_r};
      mfhic_pkg::REG_FIELD_LIMIT: cfg_prdata = {17'h0, limit_r};
      default:                    cfg_prdata = 32'h0;
    endcase
  end

  assign filter_gain = gain_r;
  assign field_limit = limit_r;

endmodule

// ===== hw/rtl/mfhic_axis_filter.sv =====
// ----------------------------------------------------------------------------
// mfhic_axis_filter: one axis of offset correction and low-pass filter
// Holds the Q16.16 filter state and tests it against the field limit.
// ----------------------------------------------------------------------------
module mfhic_axis_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           upd,
  input  logic [mfhic_pkg::SAMPLE_W-1:0] raw,
  input  logic [mfhic_pkg::SAMPLE_W-1:0] offset,
  input  logic [mfhic_pkg::GAIN_W-1:0]   gain,
  input  logic [mfhic_pkg::LIMIT_W-1:0]  limit,
  output logic [mfhic_pkg::SAMPLE_W-1:0] mag,
  output logic                           in_field
);

  logic signed [mfhic_pkg::ACC_W-1:0] acc_r;
  logic signed [mfhic_pkg::ACC_W-1:0] acc_nxt;
  logic signed [16:0]                 diff_c;
  logic signed [15:0]                 corr;
  logic signed [32:0]                 diff;
  logic signed [49:0]                 prod;
  logic signed [32:0]                 acc_ext;
  logic signed [32:0]                 lim_pos;
  logic signed [32:0]                 lim_neg;

  // Saturating offset subtraction
  always_comb begin
    diff_c = {raw[15], raw} - {offset[15], offset};
    if (diff_c > 17'sd32767) begin
      corr = 16'sh7FFF;
    end else if (diff_c < -17'sd32768) begin
      corr = -16'sh8000;
    end else begin
      corr = diff_c[15:0];
    end
  end

  // acc' = acc + floor(g * (c*2^16 - acc) / 2^16); exact, stays in 32 bits
  always_comb begin
    diff    = {corr[15], corr, 16'h0} - {acc_r[31], acc_r};
    prod    = diff * $signed({1'b0, gain});
    acc_nxt = acc_r + prod[47:16];
  end

  // Pass when |acc'| < limit * 2^16
  always_comb begin
    acc_ext  = {acc_nxt[31], acc_nxt};
    lim_pos  = {2'b00, limit, 16'h0};
    lim_neg  = -lim_pos;
    in_field = (acc_ext < lim_pos) && (acc_ext > lim_neg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (upd) begin
      acc_r <= acc_nxt;
    end
  end

  assign mag = acc_nxt[31:16];

endmodule

// ===== hw/rtl/mfhic_cal_track.sv =====
// ----------------------------------------------------------------------------
// mfhic_cal_track: min/max hard-iron calibration
// Tracks per-axis extremes during a run and writes the offsets at its end.
// ----------------------------------------------------------------------------
module mfhic_cal_track (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   upd,
  input  logic                   cal_request,
  input  logic                   in_field,
  input  mfhic_pkg::vec3_t       raw,
  output mfhic_pkg::vec3_t       offset,
  output mfhic_pkg::vec3_t       offset_nxt,
  output mfhic_pkg::cal_status_t status
);

  mfhic_pkg::vec3_t              max_r, min_r, max_nxt, min_nxt, max_upd, min_upd;
  mfhic_pkg::vec3_t              off_r, off_nxt;
  logic [mfhic_pkg::CNT_W-1:0]   cnt_r, cnt_nxt, cnt_inc;
  logic                          run_r, run_nxt, run_eff, done;
  logic signed [16:0]            sum;

  always_comb begin
    run_eff = run_r || cal_request;
    cnt_inc = (run_r ? cnt_r : '0) + 1'b1;
    done    = run_eff && (cnt_inc == mfhic_pkg::CAL_SAMPLES);
    max_nxt = max_r;
    min_nxt = min_r;
    max_upd = max_r;
    min_upd = min_r;
    off_nxt = off_r;
    sum     = '0;
    run_nxt = run_eff;
    cnt_nxt = run_eff ? cnt_inc : cnt_r;
    for (int i = 0; i < 3; i++) begin
      if (run_eff && in_field) begin
        if ($signed(raw[i]) > $signed(max_r[i])) max_upd[i] = raw[i];
        if ($signed(raw[i]) < $signed(min_r[i])) min_upd[i] = raw[i];
      end
      max_nxt[i] = max_upd[i];
      min_nxt[i] = min_upd[i];
      if (done) begin
        sum        = {max_upd[i][15], max_upd[i]} + {min_upd[i][15], min_upd[i]};
        off_nxt[i] = sum[16:1];
        max_nxt[i] = mfhic_pkg::EXT_MAX_INIT;
        min_nxt[i] = mfhic_pkg::EXT_MIN_INIT;
      end
    end
    if (done) begin
      cnt_nxt = '0;
      run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
      off_r <= '0;
      for (int i = 0; i < 3; i++) begin
        max_r[i] <= mfhic_pkg::EXT_MAX_INIT;
        min_r[i] <= mfhic_pkg::EXT_MIN_INIT;
      end
    end else if (upd) begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
      off_r <= off_nxt;
      max_r <= max_nxt;
      min_r <= min_nxt;
    end
  end

  assign offset            = off_r;
  assign offset_nxt        = off_nxt;
  assign status.active_nxt = run_nxt;
  assign status.done_nxt   = done;

endmodule

// ===== hw/rtl/magnetometer_filter_and_hard_iron_cal_core.sv =====
// ----------------------------------------------------------------------------
// magnetometer_filter_and_hard_iron_cal_core: magnetometer front end
// Axis remap, hard-iron correction, low-pass filter and min/max calibration.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one three-axis reading per transfer; tuser carries the request
//           to start a calibration run.
//   out_* : one result per reading: filtered axes, current offsets and the
//           calibration flags.
//   cfg_* : filter gain (Q0.16) at byte 0, field limit at byte 4. Write only
//           while no reading is in flight.
// An input transfer loads the input register; when it advances, the result of
// the whole per-axis datapath (one 33x17 multiply each) moves into the result
// register, which raises out_tvalid.
// Throughput is one reading per cycle while the receiver does not stall, as
// the filter state update feeds the next reading.
// Reset clears the filter state, offsets and calibration run and loads the
// default register values. When the receiver stalls, the result register
// holds, the input register fills, and in_tready drops until out_tready rises.
// ----------------------------------------------------------------------------
module magnetometer_filter_and_hard_iron_cal_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // raw_hx[15:0], raw_hy[31:16], raw_hz[47:32]
  input  logic        in_tuser,   // cal_request
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // mag_x, mag_y, mag_z, offset_x, offset_y, offset_z
  output logic [1:0]  out_tuser,  // cal_active[0], cal_done[1]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [mfhic_pkg::GAIN_W-1:0]  gain;
  logic [mfhic_pkg::LIMIT_W-1:0] limit;

  logic                          in_valid_r;
  logic [47:0]                   in_data_r;
  logic                          in_req_r;
  logic                          advance;

  mfhic_pkg::vec3_t              raw, mag, offset, offset_nxt;
  logic [2:0]                    axis_ok;
  logic                          all_ok;
  mfhic_pkg::cal_status_t        status;

  logic                          out_valid_r;
  logic [95:0]                   out_data_r;
  logic [1:0]                    out_user_r;

  mfhic_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .filter_gain (gain),
    .field_limit (limit)
  );

  // Advance the input register into the result register when the result
  // slot is free or being taken this cycle.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_req_r  <= in_tuser;
    end
  end

  // Remap: x from sensor Y, y from sensor X, z is sensor Z negated with
  // saturation of the most negative code.
  always_comb begin
    raw[0] = in_data_r[31:16];
    raw[1] = in_data_r[15:0];
    if (in_data_r[47:32] == 16'h8000) begin
      raw[2] = 16'h7FFF;
    end else begin
      raw[2] = 16'(-$signed(in_data_r[47:32]));
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    mfhic_axis_filter u_filt (
      .clk      (clk),
      .rst_n    (rst_n),
      .upd      (advance),
      .raw      (raw[a]),
      .offset   (offset[a]),
      .gain     (gain),
      .limit    (limit),
      .mag      (mag[a]),
      .in_field (axis_ok[a])
    );
  end

  // Track extremes only when all three filtered axes are inside the limit
  assign all_ok = &axis_ok;

  mfhic_cal_track u_cal (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (advance),
    .cal_request (in_req_r),
    .in_field    (all_ok),
    .raw         (raw),
    .offset      (offset),
    .offset_nxt  (offset_nxt),
    .status      (status)
  );

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {offset_nxt[2], offset_nxt[1], offset_nxt[0], mag[2], mag[1], mag[0]};
      out_user_r <= {status.done_nxt, status.active_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== hw/rtl/mfhic_checker.sv =====
// ----------------------------------------------------------------------------
// mfhic_checker: port-level checks for the magnetometer filter core
// Watches the result channel and input ready over time.
// ----------------------------------------------------------------------------
module mfhic_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // The item that ends a run never reports the run as still active
  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0])
    else $error("cal_done with cal_active set");

  // With the result slot empty, the input side must be open
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty result register");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind magnetometer_filter_and_hard_iron_cal_core mfhic_checker u_mfhic_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
